@@ design/fxa_pkg.sv @@
// Shared types and operation codes for the fixed-point ALU.
// No dependencies.
package fxa_pkg;
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_GT = 4'd4;
  localparam logic [3:0] OP_LT = 4'd5;
  localparam logic [3:0] OP_GE = 4'd6;
  localparam logic [3:0] OP_LE = 4'd7;
  localparam logic [3:0] OP_EQ = 4'd8;
  localparam logic [3:0] OP_NE = 4'd9;
  localparam logic [3:0] OP_INC = 4'd10;
  localparam logic [3:0] OP_DEC = 4'd11;
  localparam logic [3:0] OP_MIN = 4'd12;
  localparam logic [3:0] OP_MAX = 4'd13;
  localparam logic [3:0] OP_TO_INT = 4'd14;
  localparam logic [3:0] OP_FROM_INT = 4'd15;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        neg;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  status;
  } fxa_ctl_t;
endpackage

@@ design/fxa_if.sv @@
// Valid/ready channel interfaces for ALU requests and results.
// No dependencies.
interface fxa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fxa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic [1:0]         status;
  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink (input valid, result_value, compare_true, status, output ready);
endinterface

@@ design/fxa_front.sv @@
// Front end: operand register with multiplier, then all non-divide results
// and divider setup. Depends on fxa_pkg.
module fxa_front #(
  parameter int FRAC_BITS = 8,
  parameter int QW = 32 + FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [3:0]          in_action,
  input  logic signed [31:0]  in_a,
  input  logic signed [31:0]  in_b,
  output fxa_pkg::fxa_ctl_t   ctl_o,
  output logic [QW-1:0]       nq_o,
  output logic [31:0]         den_o
);
  import fxa_pkg::*;

  localparam int WW = 32 + FRAC_BITS;

  logic               va_r;
  logic [3:0]         op_r;
  logic signed [31:0] a_r, b_r;
  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
    if (en) begin
      op_r   <= in_action;
      a_r    <= in_a;
      b_r    <= in_b;
      prod_r <= 64'(in_a * in_b);
    end
  end

  fxa_ctl_t           ctl_nxt, ctl_r;
  logic [QW-1:0]      nq_nxt, nq_r;
  logic [31:0]        den_nxt, den_r;
  logic signed [32:0] sum, dif;
  logic [63:0]        pm, pq;
  logic signed [WW-1:0] fi;
  logic [31:0]        amag;
  logic               pneg;

  always_comb begin
    ctl_nxt        = '0;
    ctl_nxt.valid  = va_r;
    ctl_nxt.status = ST_OK;
    sum  = 33'(a_r) + 33'(b_r);
    dif  = 33'(a_r) - 33'(b_r);
    pneg = prod_r[63];
    pm   = pneg ? 64'(-prod_r) : 64'(prod_r);
    pq   = (pm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    fi   = WW'(a_r) <<< FRAC_BITS;
    amag = a_r[31] ? 32'(-a_r) : 32'(a_r);
    nq_nxt  = {amag, {FRAC_BITS{1'b0}}};
    den_nxt = b_r[31] ? 32'(-b_r) : 32'(b_r);
    case (op_r)
      OP_ADD: begin
        if (sum > 33'(S32_MAX)) begin
          ctl_nxt.res = S32_MAX; ctl_nxt.status = ST_SAT;
        end else if (sum < 33'(S32_MIN)) begin
          ctl_nxt.res = S32_MIN; ctl_nxt.status = ST_SAT;
        end else ctl_nxt.res = sum[31:0];
      end
      OP_SUB: begin
        if (dif > 33'(S32_MAX)) begin
          ctl_nxt.res = S32_MAX; ctl_nxt.status = ST_SAT;
        end else if (dif < 33'(S32_MIN)) begin
          ctl_nxt.res = S32_MIN; ctl_nxt.status = ST_SAT;
        end else ctl_nxt.res = dif[31:0];
      end
      OP_MUL: begin
        if (!pneg && pq > 64'h7FFFFFFF) begin
          ctl_nxt.res = S32_MAX; ctl_nxt.status = ST_SAT;
        end else if (pneg && pq > 64'h80000000) begin
          ctl_nxt.res = S32_MIN; ctl_nxt.status = ST_SAT;
        end else ctl_nxt.res = pneg ? 32'(-pq) : pq[31:0];
      end
      OP_DIV: begin
        if (b_r == 32'sd0) begin
          ctl_nxt.status = ST_DIV0;
          ctl_nxt.res = (a_r > 0) ? S32_MAX : ((a_r < 0) ? S32_MIN : 32'd0);
        end else begin
          ctl_nxt.is_div = 1'b1;
          ctl_nxt.neg    = a_r[31] ^ b_r[31];
        end
      end
      OP_GT: ctl_nxt.cmp = a_r > b_r;
      OP_LT: ctl_nxt.cmp = a_r < b_r;
      OP_GE: ctl_nxt.cmp = a_r >= b_r;
      OP_LE: ctl_nxt.cmp = a_r <= b_r;
      OP_EQ: ctl_nxt.cmp = a_r == b_r;
      OP_NE: ctl_nxt.cmp = a_r != b_r;
      OP_INC: ctl_nxt.res = a_r + 32'sd1;
      OP_DEC: ctl_nxt.res = a_r - 32'sd1;
      OP_MIN: ctl_nxt.res = (a_r < b_r) ? a_r : b_r;
      OP_MAX: ctl_nxt.res = (a_r > b_r) ? a_r : b_r;
      OP_TO_INT: ctl_nxt.res = 32'(a_r >>> FRAC_BITS);
      OP_FROM_INT: begin
        if (fi > WW'(S32_MAX)) begin
          ctl_nxt.res = S32_MAX; ctl_nxt.status = ST_SAT;
        end else if (fi < WW'(S32_MIN)) begin
          ctl_nxt.res = S32_MIN; ctl_nxt.status = ST_SAT;
        end else ctl_nxt.res = fi[31:0];
      end
      default: ctl_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    if (en) begin
      ctl_r.is_div <= ctl_nxt.is_div;
      ctl_r.neg    <= ctl_nxt.neg;
      ctl_r.res    <= ctl_nxt.res;
      ctl_r.cmp    <= ctl_nxt.cmp;
      ctl_r.status <= ctl_nxt.status;
      nq_r  <= nq_nxt;
      den_r <= den_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign nq_o  = nq_r;
  assign den_o = den_r;
endmodule

@@ design/fxa_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per transaction.
// Depends on fxa_pkg.
module fxa_div_cell #(
  parameter int QW = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  fxa_pkg::fxa_ctl_t ctl_i,
  input  logic [31:0]       rem_i,
  input  logic [QW-1:0]     nq_i,
  input  logic [31:0]       den_i,
  output fxa_pkg::fxa_ctl_t ctl_o,
  output logic [31:0]       rem_o,
  output logic [QW-1:0]     nq_o,
  output logic [31:0]       den_o
);
  import fxa_pkg::*;

  fxa_ctl_t      ctl_r;
  logic [31:0]   rem_r, den_r;
  logic [QW-1:0] nq_r;
  logic [32:0]   t, d;
  logic          ge;

  always_comb begin
    t  = {rem_i, nq_i[QW-1]};
    ge = t >= {1'b0, den_i};
    d  = t - {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
    if (en) begin
      ctl_r.is_div <= ctl_i.is_div;
      ctl_r.neg    <= ctl_i.neg;
      ctl_r.res    <= ctl_i.res;
      ctl_r.cmp    <= ctl_i.cmp;
      ctl_r.status <= ctl_i.status;
      rem_r <= ge ? d[31:0] : t[31:0];
      nq_r  <= {nq_i[QW-2:0], ge};
      den_r <= den_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign nq_o  = nq_r;
  assign den_o = den_r;
endmodule

@@ design/fxa_back.sv @@
// Output stage: divide rounding, sign and saturation, result register.
// Depends on fxa_pkg.
module fxa_back #(
  parameter int QW = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  fxa_pkg::fxa_ctl_t ctl_i,
  input  logic [31:0]       rem_i,
  input  logic [QW-1:0]     q_i,
  input  logic [31:0]       den_i,
  output logic              valid_o,
  output logic [31:0]       res_o,
  output logic              cmp_o,
  output logic [1:0]        status_o
);
  import fxa_pkg::*;

  logic          valid_r, cmp_r;
  logic [31:0]   res_r, res_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [QW:0]   qr;
  logic          rnd;

  always_comb begin
    rnd = {rem_i, 1'b0} >= {1'b0, den_i};
    qr  = {1'b0, q_i} + (QW+1)'(rnd);
    res_nxt    = ctl_i.res;
    status_nxt = ctl_i.status;
    if (ctl_i.is_div) begin
      if (!ctl_i.neg && qr > (QW+1)'(32'h7FFFFFFF)) begin
        res_nxt = S32_MAX; status_nxt = ST_SAT;
      end else if (ctl_i.neg && qr > (QW+1)'(32'h80000000)) begin
        res_nxt = S32_MIN; status_nxt = ST_SAT;
      end else begin
        res_nxt = ctl_i.neg ? 32'(-qr[31:0]) : qr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
    if (en) begin
      res_r    <= res_nxt;
      cmp_r    <= ctl_i.cmp;
      status_r <= status_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign res_o    = res_r;
  assign cmp_o    = cmp_r;
  assign status_o = status_r;
endmodule

@@ design/fixed_point_alu.sv @@
// Top level of the signed fixed-point ALU: front end, division cell row,
// output stage. Depends on fxa_pkg, fxa_if, fxa_front, fxa_div_cell, fxa_back.
//
//   channel  dir  payload
//   in_ch    in   action, operand_a, operand_b
//   out_ch   out  result_value, compare_true, status
//
// One transaction per cycle while out_ch is not stalled. Every op passes the
// front end, 32 + FRAC_BITS division cells (one quotient bit each), fxa_back.
// Synchronous active-low reset empties the pipeline.
// A stalled output freezes the whole pipeline; in_ch.ready follows it.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  fxa_in_if.sink    in_ch,
  fxa_out_if.source out_ch
);
  import fxa_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  logic en;
  logic [31:0] res;

  fxa_ctl_t      ctl [0:QW];
  logic [31:0]   rem [0:QW];
  logic [QW-1:0] nq  [0:QW];
  logic [31:0]   den [0:QW];

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign rem[0] = '0;

  fxa_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_ch.valid), .in_action(in_ch.action),
    .in_a(in_ch.operand_a), .in_b(in_ch.operand_b),
    .ctl_o(ctl[0]), .nq_o(nq[0]), .den_o(den[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    fxa_div_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(ctl[i]), .rem_i(rem[i]), .nq_i(nq[i]), .den_i(den[i]),
      .ctl_o(ctl[i+1]), .rem_o(rem[i+1]), .nq_o(nq[i+1]), .den_o(den[i+1])
    );
  end

  fxa_back #(.QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_i(ctl[QW]), .rem_i(rem[QW]), .q_i(nq[QW]), .den_i(den[QW]),
    .valid_o(out_ch.valid), .res_o(res),
    .cmp_o(out_ch.compare_true), .status_o(out_ch.status)
  );

  assign out_ch.result_value = res;
endmodule
